[design/dq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Request codes, status codes, the default depth and the result info type
// shared by the queue control logic and the top level.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DQ_DEPTH_DEFAULT = 16;

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_REVERSE    = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Per-request result flags that travel with the occupancy.
    typedef struct packed {
        logic [1:0] status;
        logic       pop_valid;
    } t_res_info;

endpackage

[design/dq_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue word store
// Single-port-write, single-port-read synchronous memory with a registered
// read output that holds its value until the next enabled read.
// ----------------------------------------------------------------------------
module dq_mem #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [31:0]              i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [31:0]              o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/dq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue control
// Holds the ring indices, the occupancy count and the reverse flag, decodes
// each request and issues the matching memory write or read.
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [2:0]                 i_req_type,
    output logic                       o_we,
    output logic [$clog2(DEPTH)-1:0]   o_waddr,
    output logic                       o_re,
    output logic [$clog2(DEPTH)-1:0]   o_raddr,
    output t_res_info                  o_info,
    output logic [$clog2(DEPTH+1)-1:0] o_occupancy
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [IW-1:0] r_front, n_front;
    logic [IW-1:0] r_back,  n_back;
    logic [CW-1:0] r_count, n_count;
    logic          r_rev,   n_rev;

    logic          front_end;
    logic [IW-1:0] front_dec, front_inc, back_dec, back_inc;

    assign front_inc = (r_front == IDX_LAST) ? '0 : r_front + 1'b1;
    assign front_dec = (r_front == '0) ? IDX_LAST : r_front - 1'b1;
    assign back_inc  = (r_back == IDX_LAST) ? '0 : r_back + 1'b1;
    assign back_dec  = (r_back == '0) ? IDX_LAST : r_back - 1'b1;

    // The reverse flag swaps which physical end serves the logical front.
    assign front_end = ((i_req_type == REQ_PUSH_FRONT) || (i_req_type == REQ_POP_FRONT))
                       ^ r_rev;

    always_comb begin
        n_front        = r_front;
        n_back         = r_back;
        n_count        = r_count;
        n_rev          = r_rev;
        o_we           = 1'b0;
        o_waddr        = r_back;
        o_re           = 1'b0;
        o_raddr        = r_front;
        o_info.status    = ST_OK;
        o_info.pop_valid = 1'b0;
        case (i_req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (r_count == CNT_FULL) begin
                    o_info.status = ST_FULL;
                end else if (front_end) begin
                    n_front = front_dec;
                    o_waddr = front_dec;
                    o_we    = i_accept;
                    n_count = r_count + 1'b1;
                end else begin
                    o_waddr = r_back;
                    n_back  = back_inc;
                    o_we    = i_accept;
                    n_count = r_count + 1'b1;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (r_count == '0) begin
                    o_info.status = ST_EMPTY;
                end else if (front_end) begin
                    o_raddr          = r_front;
                    n_front          = front_inc;
                    o_re             = i_accept;
                    n_count          = r_count - 1'b1;
                    o_info.pop_valid = 1'b1;
                end else begin
                    n_back           = back_dec;
                    o_raddr          = back_dec;
                    o_re             = i_accept;
                    n_count          = r_count - 1'b1;
                    o_info.pop_valid = 1'b1;
                end
            end
            REQ_REVERSE: begin
                n_rev = ~r_rev;
            end
            default: begin
                // Unused request codes leave the queue untouched.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    assign o_occupancy = n_count;

endmodule

[design/double_ended_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of signed 32-bit words kept in a ring buffer memory.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the slave stream: s_axis_tuser carries the request code
// (push front, push back, pop front, pop back, reverse) and s_axis_tdata the
// word to push. Every accepted beat yields exactly one result beat on the
// master stream with the popped word, the occupancy after the request, a
// pop-valid flag and a status (ok, empty on a refused pop, full on a
// refused push).
// The result beat is presented right after the edge that accepts the request
// beat and can be taken at the following edge. One request is taken per cycle
// as long as the result register is empty or being drained; the registered
// memory read of a pop lands directly in the result path.
// When the receiver stalls, the result beat is held and s_axis_tready drops
// until it is taken. Reset empties the queue, clears the reverse flag and
// drops any pending result; the word memory itself is not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int DEPTH = DQ_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pop_value from bit 0, then occupancy, zero padded to whole bytes
    output logic [((32 + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser    // [0] pop_valid, [2:1] status
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = ((32 + CW + 7) / 8) * 8;

    logic          accept;
    logic          mem_we;
    logic          mem_re;
    logic [IW-1:0] mem_waddr;
    logic [IW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;
    t_res_info     res_info;
    logic [CW-1:0] res_occ;

    logic          r_out_valid;
    t_res_info     r_out_info;
    logic [CW-1:0] r_out_occ;

    // The result register doubles as the skid stage: a new request is taken
    // whenever the current result is absent or leaving this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    dq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (s_axis_tuser),
        .o_we       (mem_we),
        .o_waddr    (mem_waddr),
        .o_re       (mem_re),
        .o_raddr    (mem_raddr),
        .o_info     (res_info),
        .o_occupancy(res_occ)
    );

    // Read data stays in the memory's output register while the result
    // waits, since reads are only enabled on accepted pops.
    dq_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(s_axis_tdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_info <= res_info;
            r_out_occ  <= res_occ;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OW'({r_out_occ, (r_out_info.pop_valid ? mem_rdata : 32'd0)});
    assign m_axis_tuser  = {r_out_info.status, r_out_info.pop_valid};

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue core testbench
// Drives push, pop and reverse requests into the slave stream and checks
// every result beat against a ring buffer predictor kept in a scoreboard.
// Directed requests cover empty pops, filling to the limit, a refused push,
// both ends under reversal and unused request codes. Random bursts then
// lean toward filling, draining or neither. Both streams idle and stall at
// random, with one long receiver hold-off and one full drain midway.
// ----------------------------------------------------------------------------
module tb;
    import dq_pkg::*;

    localparam int DEPTH   = DQ_DEPTH_DEFAULT;
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int TDATA_W = ((32 + OCC_W + 7) / 8) * 8;

    // Request codes outside the defined set; the core leaves the queue untouched.
    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    localparam int RANDOM_REQS   = 500;
    localparam int LONG_HOLD     = 80;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 10;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata = '0;   // [31:0] push_value
    logic [2:0]         s_axis_tuser = '0;   // [2:0] req_type
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // [31:0] pop_value, then occupancy
    logic [2:0]         m_axis_tuser;        // [0] pop_valid, [2:1] status

    typedef struct packed {
        logic [31:0]      word;
        logic             valid;
        logic [1:0]       status;
        logic [OCC_W-1:0] occ;
    } t_deque_result;

    // Holds a private copy of the deque and the results still owed by the core.
    class deque_scoreboard;
        logic [31:0]   slots[DEPTH];
        int            head_idx;
        int            tail_idx;
        int            fill;
        bit            flipped;
        t_deque_result owed[$];
        int            errors;
        int            checked;

        function new();
            head_idx = 0;
            tail_idx = 0;
            fill     = 0;
            flipped  = 1'b0;
            errors   = 0;
            checked  = 0;
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // Apply one accepted request to the private deque and queue its result.
        function void note_request(logic [2:0] code, logic [31:0] word);
            t_deque_result r;
            bit            at_head;
            r        = '0;
            r.status = ST_OK;
            at_head  = ((code == REQ_PUSH_FRONT) || (code == REQ_POP_FRONT)) ^ flipped;
            case (code)
                REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                    if (fill >= DEPTH) begin
                        r.status = ST_FULL;
                    end else if (at_head) begin
                        head_idx = (head_idx + DEPTH - 1) % DEPTH;
                        slots[head_idx] = word;
                        fill++;
                    end else begin
                        slots[tail_idx] = word;
                        tail_idx = (tail_idx + 1) % DEPTH;
                        fill++;
                    end
                end
                REQ_POP_FRONT, REQ_POP_BACK: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else if (at_head) begin
                        r.word  = slots[head_idx];
                        r.valid = 1'b1;
                        head_idx = (head_idx + 1) % DEPTH;
                        fill--;
                    end else begin
                        tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
                        r.word  = slots[tail_idx];
                        r.valid = 1'b1;
                        fill--;
                    end
                end
                REQ_REVERSE: flipped = !flipped;
                default: ;
            endcase
            r.occ = fill[OCC_W-1:0];
            owed.push_back(r);
        endfunction

        task check_result(logic [31:0] word, logic valid, logic [1:0] status,
                          logic [OCC_W-1:0] occ);
            t_deque_result e;
            checked++;
            if (owed.size() == 0) begin
                report("result beat with no request outstanding");
                return;
            end
            e = owed.pop_front();
            if (word !== e.word)
                report($sformatf("pop_value %h, expected %h", word, e.word));
            if (valid !== e.valid)
                report($sformatf("pop_valid %b, expected %b", valid, e.valid));
            if (status !== e.status)
                report($sformatf("status %0d, expected %0d", status, e.status));
            if (occ !== e.occ)
                report($sformatf("occupancy %0d, expected %0d", occ, e.occ));
        endtask
    endclass

    deque_scoreboard sb = new();

    double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Words at the signed extremes and around zero turn up often.
    function automatic logic [31:0] pick_word(int sel);
        case (sel % 6)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_req(input logic [2:0] code, input logic [31:0] word,
                            input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= code;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(code, word);
    endtask

    task automatic run_directed();
        int k;
        send_req(REQ_POP_FRONT, 32'h0000_0000, 0);
        send_req(REQ_POP_BACK, 32'hFFFF_FFFF, 0);
        send_req(REQ_REVERSE, 32'h5A5A_A5A5, 1);
        send_req(REQ_UNUSED_LO, 32'hA5A5_5A5A, 0);
        // Fill to the limit from both ends while reversed.
        for (k = 0; k < DEPTH; k++)
            send_req(k[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_word(k),
                     (k % 3 == 0) ? 1 : 0);
        send_req(REQ_PUSH_BACK, 32'h1234_5678, 0);
        send_req(REQ_REVERSE, 32'h0000_0000, 0);
        send_req(REQ_POP_FRONT, 32'hFFFF_FFFF, 0);
        send_req(REQ_POP_BACK, 32'h0000_0000, 2);
        send_req(REQ_UNUSED_HI, 32'hFFFF_FFFF, 0);
    endtask

    // Bursts lean toward filling, draining or neither, so both bounds are hit.
    task automatic run_random(input int count);
        int          n;
        int          lean;
        bit          quiet;
        int          burst_left;
        int          r;
        logic [2:0]  code;
        logic        is_push;
        logic        at_front;
        burst_left = 0;
        lean       = 0;
        quiet      = 1'b0;
        for (n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(12, 32);
                lean       = $urandom_range(0, 2);
                quiet      = ($urandom_range(0, 3) == 0);
            end
            burst_left--;
            // Let every outstanding result come back before going on.
            if (n == count * 3 / 5) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (sb.outstanding() != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 6) begin
                code = REQ_REVERSE;
            end else if (r < 9) begin
                code = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
            end else begin
                case (lean)
                    0:       is_push = ($urandom_range(0, 99) < 75);
                    1:       is_push = ($urandom_range(0, 99) < 25);
                    default: is_push = 1'($urandom_range(0, 1));
                endcase
                at_front = 1'($urandom_range(0, 1));
                if (is_push)
                    code = at_front ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
                else
                    code = at_front ? REQ_POP_FRONT : REQ_POP_BACK;
            end
            send_req(code, ($urandom_range(0, 4) == 0) ? pick_word($urandom())
                                                       : $urandom(),
                     quiet ? 0 : pick_gap());
        end
    endtask

    // Result side: checks every taken beat and paces tready, with one long
    // hold-off once enough results have come to be deep into random traffic.
    initial begin : result_sink
        int stall_left;
        int mode_left;
        bit steady;
        bit long_done;
        stall_left = 0;
        mode_left  = 0;
        steady     = 1'b0;
        long_done  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[31:0], m_axis_tuser[0],
                                m_axis_tuser[2:1],
                                m_axis_tdata[32 +: OCC_W]);
            if (!long_done && sb.checked >= 200) begin
                long_done  = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                steady    = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(20, 80);
            end else begin
                mode_left--;
            end
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!steady)
                    stall_left = pick_gap();
            end
        end
    end

    initial begin : stimulus
        int waited;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random(RANDOM_REQS);
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (sb.outstanding() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d results never arrived", sb.outstanding()));
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule
